[sv/command_slot_table_macros.svh]
// ----------------------------------------------------------------------------
// command_slot_table_macros.svh
// Assertion macros shared by the command slot table RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_SLOT_TABLE_MACROS_SVH
`define COMMAND_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg
// Constants, operation codes and shared types of the command slot table.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Table geometry
  localparam int SLOT_COUNT    = 8;
  localparam int PAYLOAD_BYTES = 8;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
  localparam int PAY_W         = 8 * PAYLOAD_BYTES;

  // Code reported by an empty slot
  localparam logic [7:0] EMPTY_CODE = 8'hFF;

  // Operation codes carried in func
  typedef enum logic [1:0] {
    FN_INSERT    = 2'd0,
    FN_CLEAR     = 2'd1,
    FN_CLEAR_ALL = 2'd2,
    FN_READ      = 2'd3
  } cst_func_t;

  // One stored slot
  typedef struct packed {
    logic [7:0]       code;
    logic [PAY_W-1:0] payload;
  } cst_entry_t;

  // Write request into the slot store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    cst_entry_t        entry;
  } cst_wr_t;

  // Registered read response from the slot store
  typedef struct packed {
    logic       written;
    cst_entry_t entry;
  } cst_rd_t;

endpackage

[sv/cst_if.sv]
// ----------------------------------------------------------------------------
// cst_in_if / cst_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  slot_select;
  logic [7:0]  command_code;
  logic [63:0] command_data;

  modport source (output valid, func, slot_select, command_code, command_data,
                  input ready);
  modport sink   (input valid, func, slot_select, command_code, command_data,
                  output ready);
endinterface

interface cst_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        written_slot;
  logic              overwrote;
  logic              slot_occupied;
  logic [7:0]        slot_code;
  logic [63:0]       slot_payload;
  logic signed [3:0] occupied_minus_one;

  modport source (output valid, written_slot, overwrote, slot_occupied, slot_code,
                  slot_payload, occupied_minus_one, input ready);
  modport sink   (input valid, written_slot, overwrote, slot_occupied, slot_code,
                  slot_payload, occupied_minus_one, output ready);
endinterface

[sv/cst_slot_mem.sv]
// ----------------------------------------------------------------------------
// cst_slot_mem
// Slot store: one write port, one registered read port, and a written bit
// per slot so that a read reports whether the slot has ever been written.
// ----------------------------------------------------------------------------
module cst_slot_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cst_pkg::cst_wr_t            wr,
  input  logic                        rd_en,
  input  logic [cst_pkg::SLOT_W-1:0]  rd_addr,
  output cst_pkg::cst_rd_t            rd
);

  cst_pkg::cst_entry_t                mem_r [cst_pkg::SLOT_COUNT];
  cst_pkg::cst_entry_t                rd_entry_r;
  logic [cst_pkg::SLOT_COUNT-1:0]     written_r;
  logic                               rd_written_r;

  // Store array and read data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  // Track which slots hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr.en) begin
        written_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_addr];
      end
    end
  end

  assign rd.written = rd_written_r;
  assign rd.entry   = rd_entry_r;

endmodule

[sv/command_slot_table.sv]
// ----------------------------------------------------------------------------
// command_slot_table
// A result beat is offered once its command beat has passed the scan, apply
//   and response states, later while an earlier result waits on the output.
// One command at a time: the next is taken once the last result is registered;
//   the flag scan walks one slot per cycle through a single counter/compare.
// Reset: synchronous, active low; every slot empty, no result pending.
// ----------------------------------------------------------------------------
`include "command_slot_table_macros.svh"

module command_slot_table (
  input  logic      clk,
  input  logic      rst_n,
  cst_in_if.sink    in_ch,
  cst_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_t;

  localparam logic [cst_pkg::SLOT_W-1:0] LAST_SLOT =
    cst_pkg::SLOT_W'(cst_pkg::SLOT_COUNT - 1);

  state_t                          state_r, state_nxt;
  logic [cst_pkg::SLOT_W-1:0]      idx_r, idx_nxt;
  logic [cst_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            found_r, found_nxt;
  logic [cst_pkg::SLOT_W-1:0]      empty_idx_r, empty_idx_nxt;
  logic [cst_pkg::SLOT_COUNT-1:0]  flags_r, flags_nxt;
  cst_pkg::cst_func_t              func_r, func_nxt;
  logic [2:0]                      sel_r, sel_nxt;
  logic [7:0]                      code_r, code_nxt;
  logic [cst_pkg::PAY_W-1:0]       data_r, data_nxt;
  logic [cst_pkg::SLOT_W-1:0]      wslot_r, wslot_nxt;
  logic                            over_r, over_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [2:0]                      out_wslot_r, out_wslot_nxt;
  logic                            out_over_r, out_over_nxt;
  logic                            out_occ_r, out_occ_nxt;
  logic [7:0]                      out_code_r, out_code_nxt;
  logic [63:0]                     out_pay_r, out_pay_nxt;
  logic signed [3:0]               out_cnt_r, out_cnt_nxt;

  logic [cst_pkg::SLOT_W-1:0]      sel_idx;
  logic                            sel_ok;
  logic [cst_pkg::SLOT_W-1:0]      ins_slot;
  logic                            scan_flag;
  cst_pkg::cst_wr_t                wr;
  logic                            rd_en;
  cst_pkg::cst_rd_t                rd;

  assign sel_idx   = cst_pkg::SLOT_W'(sel_r);
  assign sel_ok    = int'(sel_r) < cst_pkg::SLOT_COUNT;
  assign ins_slot  = found_r ? empty_idx_r : LAST_SLOT;
  assign scan_flag = flags_r[idx_r];

  cst_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (sel_idx),
    .rd      (rd)
  );

  // Sequencer: capture, scan flags, apply the operation, deliver the beat
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    empty_idx_nxt = empty_idx_r;
    flags_nxt     = flags_r;
    func_nxt      = func_r;
    sel_nxt       = sel_r;
    code_nxt      = code_r;
    data_nxt      = data_r;
    wslot_nxt     = wslot_r;
    over_nxt      = over_r;
    out_valid_nxt = out_valid_r;
    out_wslot_nxt = out_wslot_r;
    out_over_nxt  = out_over_r;
    out_occ_nxt   = out_occ_r;
    out_code_nxt  = out_code_r;
    out_pay_nxt   = out_pay_r;
    out_cnt_nxt   = out_cnt_r;
    wr            = '0;
    rd_en         = 1'b0;

    // Drop the result once it is taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt      = cst_pkg::cst_func_t'(in_ch.func);
          sel_nxt       = in_ch.slot_select;
          code_nxt      = in_ch.command_code;
          data_nxt      = cst_pkg::PAY_W'(in_ch.command_data);
          idx_nxt       = '0;
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          empty_idx_nxt = '0;
          wslot_nxt     = '0;
          over_nxt      = 1'b0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        // Count occupied slots and note the first empty one
        cnt_nxt = cnt_r + cst_pkg::CNT_W'(scan_flag);
        if (!scan_flag && !found_r) begin
          found_nxt     = 1'b1;
          empty_idx_nxt = idx_r;
        end
        if (idx_r == LAST_SLOT) begin
          state_nxt = S_APPLY;
        end else begin
          idx_nxt = idx_r + cst_pkg::SLOT_W'(1);
        end
      end

      S_APPLY: begin
        unique case (func_r)
          cst_pkg::FN_INSERT: begin
            wr.en               = 1'b1;
            wr.addr             = ins_slot;
            wr.entry.code       = code_r;
            wr.entry.payload    = data_r;
            flags_nxt[ins_slot] = 1'b1;
            wslot_nxt           = ins_slot;
            over_nxt            = !found_r;
            if (found_r) begin
              cnt_nxt = cnt_r + cst_pkg::CNT_W'(1);
            end
          end
          cst_pkg::FN_CLEAR: begin
            if (sel_ok) begin
              flags_nxt[sel_idx] = 1'b0;
              cnt_nxt            = cnt_r - cst_pkg::CNT_W'(flags_r[sel_idx]);
            end
          end
          cst_pkg::FN_CLEAR_ALL: begin
            flags_nxt = '0;
            cnt_nxt   = '0;
          end
          cst_pkg::FN_READ: begin
            rd_en = 1'b1;
          end
          default: begin
          end
        endcase
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_wslot_nxt = 3'(wslot_r);
          out_over_nxt  = over_r;
          out_occ_nxt   = 1'b0;
          out_code_nxt  = '0;
          out_pay_nxt   = '0;
          if (func_r == cst_pkg::FN_READ) begin
            out_code_nxt = cst_pkg::EMPTY_CODE;
            if (sel_ok) begin
              if (flags_r[sel_idx]) begin
                out_occ_nxt  = 1'b1;
                out_code_nxt = rd.entry.code;
                out_pay_nxt  = 64'(rd.entry.payload);
              end else if (rd.written) begin
                // An emptied slot keeps all but its low payload byte
                out_pay_nxt = 64'(rd.entry.payload) & ~64'hFF;
              end
            end
          end
          // Count minus one, saturated at the field's top
          if (int'(cnt_r) >= 8) begin
            out_cnt_nxt = 4'sd7;
          end else begin
            out_cnt_nxt = signed'(4'(cnt_r) - 4'd1);
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      empty_idx_r <= '0;
      flags_r     <= '0;
      func_r      <= cst_pkg::FN_INSERT;
      wslot_r     <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      empty_idx_r <= empty_idx_nxt;
      flags_r     <= flags_nxt;
      func_r      <= func_nxt;
      wslot_r     <= wslot_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_r       <= sel_nxt;
    code_r      <= code_nxt;
    data_r      <= data_nxt;
    out_wslot_r <= out_wslot_nxt;
    out_over_r  <= out_over_nxt;
    out_occ_r   <= out_occ_nxt;
    out_code_r  <= out_code_nxt;
    out_pay_r   <= out_pay_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.written_slot       = out_wslot_r;
  assign out_ch.overwrote          = out_over_r;
  assign out_ch.slot_occupied      = out_occ_r;
  assign out_ch.slot_code          = out_code_r;
  assign out_ch.slot_payload       = out_pay_r;
  assign out_ch.occupied_minus_one = out_cnt_r;

  // Checks
  `CST_ASSERT_NEXT(a_accept_starts_scan, in_ch.valid && in_ch.ready,
    state_r == S_SCAN, "accepted beat did not start the scan")
  `CST_ASSERT_NEXT(a_scan_ends_in_apply, state_r == S_SCAN && idx_r == LAST_SLOT,
    state_r == S_APPLY, "scan did not hand over to apply")
  `CST_ASSERT_NOW(a_full_means_all_counted,
    state_r == S_APPLY && func_r == cst_pkg::FN_INSERT && !found_r,
    int'(cnt_r) == cst_pkg::SLOT_COUNT, "no empty slot found but count not full")
  `CST_ASSERT_NOW(a_overwrite_hits_last, out_ch.valid && out_ch.overwrote,
    out_ch.written_slot == 3'(cst_pkg::SLOT_COUNT - 1), "overwrite not on last slot")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_slot_table. A shadow copy of the slot table
// predicts every result beat as each command beat is accepted. The checker
// compares result beats field by field, in order, with the predictions.
// Directed cases cover the empty table, the full table, overwrite, clears and
// reads. Random traffic follows, with random gaps on both channels, a long
// output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic [2:0]        written_slot;
    logic              overwrote;
    logic              slot_occupied;
    logic [7:0]        slot_code;
    logic [63:0]       slot_payload;
    logic signed [3:0] occupied_minus_one;
  } slot_report_t;

  logic clk;
  logic rst_n;

  cst_in_if  in_ch ();
  cst_out_if out_ch ();

  command_slot_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the slot table
  logic                      shadow_occupied [cst_pkg::SLOT_COUNT];
  logic [7:0]                shadow_code     [cst_pkg::SLOT_COUNT];
  logic [cst_pkg::PAY_W-1:0] shadow_payload  [cst_pkg::SLOT_COUNT];

  slot_report_t expected_reports[$];

  int  error_count;
  int  reports_checked;
  int  overwrite_count;
  int  issued_by_func[4];
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  int  hold_requests;
  int  hold_seen;
  int  hold_left;
  int  quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Empty one shadow slot: flag down, empty code, payload low byte zeroed
  function automatic void clear_shadow_slot(int s);
    shadow_occupied[s] = 1'b0;
    shadow_code[s]     = cst_pkg::EMPTY_CODE;
    shadow_payload[s][7:0] = 8'h00;
  endfunction

  // Apply one command to the shadow table and return the result it produces
  function automatic slot_report_t apply_command(cst_pkg::cst_func_t fn, logic [2:0] sel,
                                                 logic [7:0] code, logic [63:0] data);
    slot_report_t r;
    int s;
    int n;
    r = '{default: '0};
    case (fn)
      cst_pkg::FN_INSERT: begin
        s = 0;
        while (s < cst_pkg::SLOT_COUNT && shadow_occupied[s]) s++;
        if (s == cst_pkg::SLOT_COUNT) begin
          s = cst_pkg::SLOT_COUNT - 1;
          clear_shadow_slot(s);
          r.overwrote = 1'b1;
        end
        shadow_payload[s]  = data[cst_pkg::PAY_W-1:0];
        shadow_code[s]     = code;
        shadow_occupied[s] = 1'b1;
        r.written_slot     = 3'(s);
      end
      cst_pkg::FN_CLEAR: begin
        if (int'(sel) < cst_pkg::SLOT_COUNT) clear_shadow_slot(int'(sel));
      end
      cst_pkg::FN_CLEAR_ALL: begin
        for (s = 0; s < cst_pkg::SLOT_COUNT; s++) clear_shadow_slot(s);
      end
      default: begin
        if (int'(sel) < cst_pkg::SLOT_COUNT) begin
          r.slot_occupied = shadow_occupied[sel];
          r.slot_code     = shadow_code[sel];
          r.slot_payload  = 64'(shadow_payload[sel]);
        end else begin
          r.slot_code = cst_pkg::EMPTY_CODE;
        end
      end
    endcase
    n = -1;
    for (s = 0; s < cst_pkg::SLOT_COUNT; s++) if (shadow_occupied[s]) n++;
    if (n > 7) n = 7;
    r.occupied_minus_one = 4'(n);
    return r;
  endfunction

  // Payloads biased toward the extremes
  function automatic logic [63:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Send one command beat; valid stays high after the handshake
  task automatic send_cmd(input cst_pkg::cst_func_t fn, input logic [2:0] sel,
                          input logic [7:0] code, input logic [63:0] data);
    slot_report_t expected;
    if (tx_gaps_on) begin
      while ($urandom_range(0, 99) < 10) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= fn;
    in_ch.slot_select  <= sel;
    in_ch.command_code <= code;
    in_ch.command_data <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected = apply_command(fn, sel, code, data);
    if (expected.overwrote) overwrite_count++;
    issued_by_func[fn]++;
    expected_reports.push_back(expected);
  endtask

  // Random command, weighted so the table often fills up
  task automatic send_random_cmd();
    int pick;
    cst_pkg::cst_func_t fn;
    pick = $urandom_range(0, 99);
    if (pick < 42)      fn = cst_pkg::FN_INSERT;
    else if (pick < 77) fn = cst_pkg::FN_READ;
    else if (pick < 95) fn = cst_pkg::FN_CLEAR;
    else                fn = cst_pkg::FN_CLEAR_ALL;
    send_cmd(fn, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), rand_payload());
  endtask

  // Drop valid and wait for every predicted result
  task automatic stop_and_drain();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Empty table, fill, overwrite, clears, reads
  task automatic test_directed();
    int i;
    send_cmd(cst_pkg::FN_READ, 3'd0, 8'h5A, '1);
    send_cmd(cst_pkg::FN_INSERT, 3'd7, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_INSERT, 3'd0, 8'hFF, '1);
    for (i = 2; i < cst_pkg::SLOT_COUNT; i++)
      send_cmd(cst_pkg::FN_INSERT, 3'($urandom_range(0, 7)), 8'(i * 37), rand_payload());
    send_cmd(cst_pkg::FN_INSERT, 3'd0, 8'hA5, '1);
    send_cmd(cst_pkg::FN_READ, 3'd7, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_CLEAR, 3'd3, 8'hFF, '1);
    send_cmd(cst_pkg::FN_READ, 3'd3, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_INSERT, 3'd0, 8'h3C, 64'h0123_4567_89AB_CDEF);
    send_cmd(cst_pkg::FN_CLEAR, 3'd3, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_CLEAR, 3'd3, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_READ, 3'd1, 8'hFF, '1);
    send_cmd(cst_pkg::FN_CLEAR_ALL, 3'd7, 8'hFF, '1);
    send_cmd(cst_pkg::FN_READ, 3'd1, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_CLEAR_ALL, 3'd0, 8'h00, 64'h0);
    send_cmd(cst_pkg::FN_INSERT, 3'd5, 8'h81, 64'h8000_0000_0000_0001);
    send_cmd(cst_pkg::FN_READ, 3'd0, 8'h00, 64'h0);
  endtask

  // No idling on either side
  task automatic test_back_to_back(int count);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (count) send_random_cmd();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Hold the output off while commands keep coming
  task automatic test_output_stall(int count);
    tx_gaps_on = 1'b0;
    hold_requests++;
    repeat (count) send_random_cmd();
    tx_gaps_on = 1'b1;
  endtask

  // Pause the sender until the table has answered everything
  task automatic test_drain_pause(int count);
    repeat (count) send_random_cmd();
    stop_and_drain();
    repeat (count) send_random_cmd();
  endtask

  task automatic test_random(int count);
    repeat (count) send_random_cmd();
  endtask

  // Result ready: random gaps plus requested long holds
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen    <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(rx_gaps_on && $urandom_range(0, 99) < 10);
    end
  end

  // Compare one field and count a mismatch
  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
      error_count++;
    end
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    slot_report_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no command pending");
        error_count++;
      end else begin
        exp = expected_reports.pop_front();
        reports_checked++;
        check_field("written_slot", 64'(exp.written_slot), 64'(out_ch.written_slot));
        check_field("overwrote", 64'(exp.overwrote), 64'(out_ch.overwrote));
        check_field("slot_occupied", 64'(exp.slot_occupied), 64'(out_ch.slot_occupied));
        check_field("slot_code", 64'(exp.slot_code), 64'(out_ch.slot_code));
        check_field("slot_payload", exp.slot_payload, out_ch.slot_payload);
        check_field("occupied_minus_one", 64'(unsigned'(exp.occupied_minus_one)),
                    64'(unsigned'(out_ch.occupied_minus_one)));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    int s;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = cst_pkg::FN_INSERT;
    in_ch.slot_select  = 3'd0;
    in_ch.command_code = 8'h00;
    in_ch.command_data = 64'h0;
    out_ch.ready       = 1'b0;
    error_count        = 0;
    reports_checked    = 0;
    overwrite_count    = 0;
    issued_by_func     = '{default: 0};
    tx_gaps_on         = 1'b1;
    rx_gaps_on         = 1'b1;
    hold_requests      = 0;
    hold_seen          = 0;
    hold_left          = 0;
    quiet_cycles       = 0;
    for (s = 0; s < cst_pkg::SLOT_COUNT; s++) begin
      shadow_occupied[s] = 1'b0;
      shadow_code[s]     = cst_pkg::EMPTY_CODE;
      shadow_payload[s]  = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_to_back(200);
    test_output_stall(40);
    test_drain_pause(40);
    test_random(700);

    // Wait out the last results, then watch for stray beats
    stop_and_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts (%0d overwrote slot %0d), %0d clears, %0d clear-alls, %0d reads",
             issued_by_func[cst_pkg::FN_INSERT], overwrite_count,
             cst_pkg::SLOT_COUNT - 1, issued_by_func[cst_pkg::FN_CLEAR],
             issued_by_func[cst_pkg::FN_CLEAR_ALL], issued_by_func[cst_pkg::FN_READ]);
    $display("Checked %0d result beats with %0d mismatches", reports_checked, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/cst_pkg.sv
sv/cst_if.sv
sv/cst_slot_mem.sv
sv/command_slot_table.sv
tb/tb.sv
